[hdl/mtfd_pkg.sv]
// Shared types, widths and helper functions of the move-to-front dedup list.
// Depends on nothing; every other file of the block imports it.
package mtfd_pkg;

  localparam int unsigned MAC_W      = 48;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NAME_WORDS = 4;
  localparam int unsigned NAME_BYTES = 32;
  localparam int unsigned RSSI_W     = 8;
  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CNT_W      = 6;

  localparam logic OP_INGEST = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef logic [NAME_WORDS-1:0][WORD_W-1:0] name_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [LEN_W-1:0]  len;
    name_t             name;
    logic [RSSI_W-1:0] rssi;
    logic [CHAN_W-1:0] chan;
  } entry_t;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
    logic              entry_valid;
    entry_t            entry;
  } result_t;

  // Clamp a name length to the longest name.
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    if (len > LEN_W'(NAME_BYTES)) begin
      return LEN_W'(NAME_BYTES);
    end
    return len;
  endfunction

  // Zero the name bytes at and beyond the length.
  function automatic name_t mask_name(input logic [LEN_W-1:0] len, input name_t name);
    logic [NAME_WORDS*WORD_W-1:0] flat;
    logic [NAME_WORDS*WORD_W-1:0] res;
    flat = name;
    res  = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (LEN_W'(b) < len) begin
        res[b*8 +: 8] = flat[b*8 +: 8];
      end
    end
    return name_t'(res);
  endfunction

endpackage

[hdl/mtfd_if.sv]
// Valid/ready channel interfaces of the move-to-front dedup list.
// Depends on mtfd_pkg for the field widths.
interface mtfd_in_if;
  import mtfd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [SLOT_W-1:0]        read_slot;
  logic [MAC_W-1:0]         mac;
  logic [LEN_W-1:0]         ssid_len;
  logic [WORD_W-1:0]        ssid_w0;
  logic [WORD_W-1:0]        ssid_w1;
  logic [WORD_W-1:0]        ssid_w2;
  logic [WORD_W-1:0]        ssid_w3;
  logic signed [RSSI_W-1:0] rssi;
  logic [CHAN_W-1:0]        chan;

  modport source (
    output valid, operation, read_slot, mac, ssid_len,
    output ssid_w0, ssid_w1, ssid_w2, ssid_w3, rssi, chan,
    input  ready
  );
  modport sink (
    input  valid, operation, read_slot, mac, ssid_len,
    input  ssid_w0, ssid_w1, ssid_w2, ssid_w3, rssi, chan,
    output ready
  );
endinterface

interface mtfd_out_if;
  import mtfd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [POS_W-1:0]         position;
  logic [CNT_W-1:0]         count;
  logic                     entry_valid;
  logic [MAC_W-1:0]         entry_mac;
  logic [LEN_W-1:0]         entry_ssid_len;
  logic [WORD_W-1:0]        entry_ssid_w0;
  logic [WORD_W-1:0]        entry_ssid_w1;
  logic [WORD_W-1:0]        entry_ssid_w2;
  logic [WORD_W-1:0]        entry_ssid_w3;
  logic signed [RSSI_W-1:0] entry_rssi;
  logic [CHAN_W-1:0]        entry_chan;

  modport source (
    output valid, hit, position, count, entry_valid, entry_mac, entry_ssid_len,
    output entry_ssid_w0, entry_ssid_w1, entry_ssid_w2, entry_ssid_w3,
    output entry_rssi, entry_chan,
    input  ready
  );
  modport sink (
    input  valid, hit, position, count, entry_valid, entry_mac, entry_ssid_len,
    input  entry_ssid_w0, entry_ssid_w1, entry_ssid_w2, entry_ssid_w3,
    input  entry_rssi, entry_chan,
    output ready
  );
endinterface

[hdl/mtfd_cell.sv]
// One list slot: holds an entry, compares it against the broadcast key and
// takes its neighbor's entry on a shift. Depends on mtfd_pkg.
module mtfd_cell #(
  parameter int unsigned INDEX    = 0,
  parameter int unsigned CNT_BITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtfd_pkg::cell_ctrl_t ctrl_i,
  input  mtfd_pkg::entry_t     key_i,
  input  mtfd_pkg::entry_t     prev_i,
  input  logic [CNT_BITS-1:0]  count_i,
  input  logic                 seen_i,
  output mtfd_pkg::entry_t     entry_o,
  output logic                 match_o,
  output logic                 seen_o
);
  import mtfd_pkg::*;

  entry_t entry_q;
  logic   match_q;
  logic   occupied;
  logic   key_eq;

  assign occupied = count_i > CNT_BITS'(INDEX);
  assign key_eq   = (entry_q.mac == key_i.mac) && (entry_q.len == key_i.len) &&
                    (entry_q.name == key_i.name);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= occupied && key_eq;
    end
  end

  // Shift in from the neighbor unless a match lies ahead of this slot.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd_en && !seen_i) begin
      entry_q <= prev_i;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign seen_o  = seen_i | match_q;

endmodule

[hdl/move_to_front_dedup_list_unit.sv]
// Top level of the move-to-front dedup list: sequencer, key register,
// row of mtfd_cell slots and result register. Depends on mtfd_pkg, mtfd_if, mtfd_cell.
//
// Usage:
//   in_i carries one transaction per operation. operation 0 ingests a record
//   (mac, ssid_len, ssid_w0..w3, rssi, chan); operation 1 reads the entry at
//   read_slot. out_o returns exactly one result transaction per input.
//   An item passes through accept, compare (on an ingest, every cell checks
//   its entry against the key at once and registers a match flag) and update
//   (the cells ahead of the match and the matching cell, or all of them on a
//   miss, take their neighbor's entry and slot 0 takes the new record).
//   A new item is accepted only once the previous one has written its
//   result; the result register is written in the update step.
//   Reset clears the entry count and the sequencer; entry contents are not
//   cleared, slots at or beyond the count are never reported.
//   When out_o stalls, the result register holds; the block still accepts
//   and compares the next item, then waits in the update step until the
//   result register frees up.
module move_to_front_dedup_list_unit #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtfd_in_if.sink     in_i,
  mtfd_out_if.source  out_o
);
  import mtfd_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PW       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                out_valid_q;
  result_t             out_q;

  logic                op_q;
  logic [SLOT_W-1:0]   slot_q;
  entry_t              key_q;
  entry_t              rd_q;

  cell_ctrl_t          ctrl;
  entry_t              cell_entry [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match;
  logic [LIST_DEPTH:0]   seen;

  logic                in_fire;
  logic                res_write;
  logic                hit;
  logic [PW-1:0]       pos;
  logic                rd_valid;
  entry_t              rd_sel;
  logic [LEN_W-1:0]    in_len;
  result_t             res;

  // Handshakes.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign res_write  = (state_q == S_UPD) && (!out_valid_q || out_o.ready);

  assign ctrl.cmp_en = (state_q == S_CMP) && (op_q == OP_INGEST);
  assign ctrl.upd_en = res_write && (op_q == OP_INGEST);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (res_write) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Capture the key with its name masked to the clamped length.
  assign in_len = sat_len(in_i.ssid_len);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q          <= in_i.operation;
      slot_q        <= in_i.read_slot;
      key_q.mac     <= in_i.mac;
      key_q.len     <= in_len;
      key_q.name    <= mask_name(in_len, {in_i.ssid_w3, in_i.ssid_w2,
                                          in_i.ssid_w1, in_i.ssid_w0});
      key_q.rssi    <= in_i.rssi;
      key_q.chan    <= in_i.chan;
    end
  end

  // Cell row; slot 0 takes the key, each later slot its neighbor.
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    entry_t prev;
    if (i == 0) begin : g_head
      assign prev = key_q;
    end else begin : g_body
      assign prev = cell_entry[i-1];
    end
    mtfd_cell #(
      .INDEX    (i),
      .CNT_BITS (CNT_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .key_i   (key_q),
      .prev_i  (prev),
      .count_i (count_q),
      .seen_i  (seen[i]),
      .entry_o (cell_entry[i]),
      .match_o (match[i]),
      .seen_o  (seen[i+1])
    );
  end

  // Entries are unique, so at most one match flag is set.
  assign hit = seen[LIST_DEPTH];

  always_comb begin
    pos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (match[i]) pos = pos | PW'(i);
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.upd_en && !hit && (count_q < CNT_BITS'(LIST_DEPTH))) begin
      count_d = count_q + CNT_BITS'(1);
    end
  end

  // Read path: select the slot during compare, register it.
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (32'(slot_q) == 32'(i)) rd_sel = cell_entry[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CMP) begin
      rd_q <= rd_sel;
    end
  end

  assign rd_valid = 32'(slot_q) < 32'(count_q);

  // Assemble the result.
  always_comb begin
    res = '0;
    if (op_q == OP_READ) begin
      res.count       = CNT_W'(count_q);
      res.entry_valid = rd_valid;
      if (rd_valid) res.entry = rd_q;
    end else begin
      res.hit      = hit;
      res.position = hit ? POS_W'(pos) : '0;
      res.count    = CNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_write) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_write) begin
      out_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.hit            = out_q.hit;
  assign out_o.position       = out_q.position;
  assign out_o.count          = out_q.count;
  assign out_o.entry_valid    = out_q.entry_valid;
  assign out_o.entry_mac      = out_q.entry.mac;
  assign out_o.entry_ssid_len = out_q.entry.len;
  assign out_o.entry_ssid_w0  = out_q.entry.name[0];
  assign out_o.entry_ssid_w1  = out_q.entry.name[1];
  assign out_o.entry_ssid_w2  = out_q.entry.name[2];
  assign out_o.entry_ssid_w3  = out_q.entry.name[3];
  assign out_o.entry_rssi     = out_q.entry.rssi;
  assign out_o.entry_chan     = out_q.entry.chan;

endmodule

[hdl/mtfd_checker.sv]
// Port-level checks of the move-to-front dedup list, bound to the top level.
// Depends on mtfd_pkg.
module mtfd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_hit_i,
  input logic [mtfd_pkg::POS_W-1:0]  out_position_i,
  input logic [mtfd_pkg::CNT_W-1:0]  out_count_i,
  input logic                        out_entry_valid_i,
  input logic [mtfd_pkg::LEN_W-1:0]  out_entry_ssid_len_i
);
  import mtfd_pkg::*;

  // A result waiting on the receiver stays up.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its summary fields.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_hit_i) && $stable(out_position_i) && $stable(out_count_i))
    else $error("stalled result changed");

  // A miss reports position zero.
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_hit_i |-> out_position_i == '0)
    else $error("miss with nonzero position");

  // A read result with a valid entry never reports a hit and has a legal length.
  a_read_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_entry_valid_i |->
      !out_hit_i && (out_entry_ssid_len_i <= LEN_W'(NAME_BYTES)))
    else $error("malformed read result");

endmodule

bind move_to_front_dedup_list_unit mtfd_checker u_mtfd_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_hit_i            (out_o.hit),
  .out_position_i       (out_o.position),
  .out_count_i          (out_o.count),
  .out_entry_valid_i    (out_o.entry_valid),
  .out_entry_ssid_len_i (out_o.entry_ssid_len)
);

[tb/mtfd_list_checker.sv]
// Response checker for the move-to-front dedup list: tracks the station list,
// predicts one response per accepted request and compares it on the out channel.
// Depends on mtfd_pkg and the mtfd_in_if / mtfd_out_if channel interfaces.
module mtfd_list_checker
  import mtfd_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtfd_in_if          in_ch_i,
  mtfd_out_if         out_ch_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t      stations [LIST_DEPTH];
  int unsigned listed     = 0;
  int unsigned mismatches = 0;
  result_t     awaited_responses [$];
  result_t     want;

  function automatic void log_failure(string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endfunction

  function automatic void check_field(string field, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      log_failure($sformatf("mismatch on %s: expected %h, actual %h", field, exp_val, act_val));
    end
  endfunction

  // Keep the first n name bytes, zero the rest.
  function automatic name_t clip_name(logic [LEN_W-1:0] n, name_t raw);
    name_t kept;
    kept = '0;
    for (int k = 0; k < NAME_WORDS; k++) begin
      for (int b = 0; b < 8; b++) begin
        if (k * 8 + b < n) kept[k][b*8 +: 8] = raw[k][b*8 +: 8];
      end
    end
    return kept;
  endfunction

  // Apply one request to the tracked list and return the response it causes.
  function automatic result_t update_station_list(
    logic op, logic [SLOT_W-1:0] slot, logic [MAC_W-1:0] mac, logic [LEN_W-1:0] raw_len,
    name_t raw_name, logic [RSSI_W-1:0] rssi, logic [CHAN_W-1:0] chan
  );
    result_t     resp;
    entry_t      rec;
    bit          found;
    int unsigned pos;
    int unsigned last;
    resp = '0;
    if (op == OP_READ) begin
      resp.count = CNT_W'(listed);
      if (slot < listed) begin
        resp.entry_valid = 1'b1;
        resp.entry       = stations[slot];
      end
      return resp;
    end
    rec.mac  = mac;
    rec.len  = (raw_len > NAME_BYTES) ? LEN_W'(NAME_BYTES) : raw_len;
    rec.name = clip_name(rec.len, raw_name);
    rec.rssi = rssi;
    rec.chan = chan;
    found = 1'b0;
    pos   = 0;
    for (int i = 0; i < listed; i++) begin
      if (!found && stations[i].mac == rec.mac && stations[i].len == rec.len &&
          stations[i].name == rec.name) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (found) begin
      last = pos;
    end else begin
      if (listed < LIST_DEPTH) listed++;
      last = listed - 1;
    end
    for (int j = last; j > 0; j--) stations[j] = stations[j-1];
    stations[0]   = rec;
    resp.hit      = found;
    resp.position = found ? POS_W'(pos) : '0;
    resp.count    = CNT_W'(listed);
    return resp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listed = 0;
      awaited_responses.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (in_ch_i.valid && in_ch_i.ready) begin
        awaited_responses.push_back(update_station_list(
          in_ch_i.operation, in_ch_i.read_slot, in_ch_i.mac, in_ch_i.ssid_len,
          {in_ch_i.ssid_w3, in_ch_i.ssid_w2, in_ch_i.ssid_w1, in_ch_i.ssid_w0},
          in_ch_i.rssi, in_ch_i.chan));
      end
      if (out_ch_i.valid && out_ch_i.ready) begin
        if (awaited_responses.size() == 0) begin
          log_failure("response with no request outstanding");
        end else begin
          want = awaited_responses.pop_front();
          check_field("hit", want.hit, out_ch_i.hit);
          check_field("position", want.position, out_ch_i.position);
          check_field("count", want.count, out_ch_i.count);
          check_field("entry_valid", want.entry_valid, out_ch_i.entry_valid);
          check_field("entry_mac", want.entry.mac, out_ch_i.entry_mac);
          check_field("entry_ssid_len", want.entry.len, out_ch_i.entry_ssid_len);
          check_field("entry_ssid_w0", want.entry.name[0], out_ch_i.entry_ssid_w0);
          check_field("entry_ssid_w1", want.entry.name[1], out_ch_i.entry_ssid_w1);
          check_field("entry_ssid_w2", want.entry.name[2], out_ch_i.entry_ssid_w2);
          check_field("entry_ssid_w3", want.entry.name[3], out_ch_i.entry_ssid_w3);
          check_field("entry_rssi", want.entry.rssi, $unsigned(out_ch_i.entry_rssi));
          check_field("entry_chan", want.entry.chan, out_ch_i.entry_chan);
        end
      end
      pending_o    <= awaited_responses.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[tb/tb_move_to_front_dedup_list_unit.sv]
// Testbench top of the move-to-front dedup list: clock, reset, request and response
// traffic, watchdog and verdict. Depends on mtfd_pkg, mtfd_if, the DUT, mtfd_list_checker.
module tb_move_to_front_dedup_list_unit;
  import mtfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH    = 32;
  localparam int unsigned RANDOM_ITEMS  = 1430;
  localparam int unsigned POOL_SIZE     = 40;
  localparam int unsigned HOLD_AT       = 350;   // random item that starts the long hold-off
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned HOLD_BURST    = 32;    // back-to-back items offered during it
  localparam int unsigned PAUSE_AT      = 760;   // random item before which the sender drains
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 16;

  // One request as the sender sees it.
  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [MAC_W-1:0]  mac;
    logic [LEN_W-1:0]  len;
    name_t             words;
    logic [RSSI_W-1:0] rssi;
    logic [CHAN_W-1:0] chan;
  } request_t;

  // Identity of a station record: address, length and raw name bytes.
  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [LEN_W-1:0] len;
    name_t            words;
  } station_key_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned quiet_cycles;

  // Shared between the sender and the receiver process.
  bit steady_flow  = 1'b0;   // both sides run without gaps
  bit hold_request = 1'b0;   // receiver starts a long hold-off

  station_key_t known_keys [POOL_SIZE];

  mtfd_in_if  req_if ();
  mtfd_out_if rsp_if ();

  move_to_front_dedup_list_unit #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  mtfd_list_checker #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch_i      (req_if),
    .out_ch_i     (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Most gaps are a few cycles, some medium, a rare one long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 16) return $urandom_range(1, 3);
    if (roll < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic name_t random_name();
    name_t w;
    for (int k = 0; k < NAME_WORDS; k++) w[k] = {$urandom, $urandom};
    return w;
  endfunction

  // Build an ingest transaction; the unused read slot carries noise.
  function automatic request_t ingest_req(logic [MAC_W-1:0] mac, logic [LEN_W-1:0] len,
                                          name_t words, logic [RSSI_W-1:0] rssi,
                                          logic [CHAN_W-1:0] chan);
    request_t r;
    r.op    = OP_INGEST;
    r.slot  = SLOT_W'($urandom);
    r.mac   = mac;
    r.len   = len;
    r.words = words;
    r.rssi  = rssi;
    r.chan  = chan;
    return r;
  endfunction

  // Build a read transaction; the record fields carry noise the block must ignore.
  function automatic request_t read_req(logic [SLOT_W-1:0] slot);
    request_t r;
    r      = ingest_req({16'($urandom), 32'($urandom)}, LEN_W'($urandom), random_name(),
                        RSSI_W'($urandom), CHAN_W'($urandom_range(0, 14)));
    r.op   = OP_READ;
    r.slot = slot;
    return r;
  endfunction

  // Replace every name byte past the (clamped) length with fresh noise.
  function automatic name_t scramble_tail(logic [LEN_W-1:0] len, name_t words);
    name_t       r;
    int unsigned kept;
    r    = words;
    kept = (len > NAME_BYTES) ? NAME_BYTES : len;
    for (int b = kept; b < NAME_BYTES; b++) r[b/8][(b%8)*8 +: 8] = 8'($urandom);
    return r;
  endfunction

  function automatic station_key_t fresh_key();
    station_key_t k;
    int unsigned  shape;
    shape = $urandom_range(0, 9);
    // Crowd a few addresses so that names alone tell records apart.
    k.mac = ($urandom_range(0, 3) == 0) ? MAC_W'($urandom_range(0, 3))
                                        : {16'($urandom), 32'($urandom)};
    case (shape)
      0:       k.len = '0;
      1:       k.len = LEN_W'(NAME_BYTES);
      2:       k.len = LEN_W'($urandom_range(NAME_BYTES + 1, 63));
      default: k.len = LEN_W'($urandom_range(1, NAME_BYTES - 1));
    endcase
    k.words = random_name();
    return k;
  endfunction

  // Ingest mix: new stations, repeats of known ones (hits while they are still
  // listed) and near misses that differ in one address bit, the length or one name bit.
  function automatic request_t make_ingest();
    station_key_t k;
    int unsigned  pick;
    int unsigned  kept;
    int unsigned  b;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      k = fresh_key();
      known_keys[$urandom_range(0, POOL_SIZE - 1)] = k;
    end else begin
      k = known_keys[$urandom_range(0, POOL_SIZE - 1)];
      // Any length of 32 or more names the same record.
      if (k.len >= NAME_BYTES) k.len = LEN_W'($urandom_range(NAME_BYTES, 63));
      kept = (k.len > NAME_BYTES) ? NAME_BYTES : k.len;
      if (pick >= 85) begin
        case ($urandom_range(0, 2))
          0: k.mac[$urandom_range(0, MAC_W - 1)] ^= 1'b1;
          1: k.len = (k.len == 0) ? LEN_W'(1) : k.len - 1'b1;
          default: begin
            if (kept != 0) begin
              b = $urandom_range(0, kept - 1);
              k.words[b/8][(b%8)*8 + $urandom_range(0, 7)] ^= 1'b1;
            end
          end
        endcase
      end
    end
    return ingest_req(k.mac, k.len, scramble_tail(k.len, k.words), RSSI_W'($urandom),
                      CHAN_W'($urandom_range(0, 14)));
  endfunction

  // Offer one transaction, hold it until accepted, then maybe idle a while.
  task automatic send_request(input request_t r, input bit may_idle);
    req_if.valid     <= 1'b1;
    req_if.operation <= r.op;
    req_if.read_slot <= r.slot;
    req_if.mac       <= r.mac;
    req_if.ssid_len  <= r.len;
    req_if.ssid_w0   <= r.words[0];
    req_if.ssid_w1   <= r.words[1];
    req_if.ssid_w2   <= r.words[2];
    req_if.ssid_w3   <= r.words[3];
    req_if.rssi      <= r.rssi;
    req_if.chan      <= r.chan;
    do @(posedge clk_i); while (!req_if.ready);
    if (may_idle && $urandom_range(0, 2) == 0) begin
      req_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every response has come back.
  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Receiver: random ready with gaps, always ready in steady stretches,
  // and one long hold-off on request so the block backs up into its input.
  initial begin
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (steady_flow || $urandom_range(0, 2) != 0) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b0;
        gap = pick_gap();
        repeat (gap - 1) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    request_t    req;
    int unsigned sent;
    int unsigned seg_items;
    int unsigned burst_left;
    // Hold every block input at a known value through reset.
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_INGEST;
    req_if.read_slot <= '0;
    req_if.mac       <= '0;
    req_if.ssid_len  <= '0;
    req_if.ssid_w0   <= '0;
    req_if.ssid_w1   <= '0;
    req_if.ssid_w2   <= '0;
    req_if.ssid_w3   <= '0;
    req_if.rssi      <= '0;
    req_if.chan      <= '0;
    for (int i = 0; i < POOL_SIZE; i++) known_keys[i] = fresh_key();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads of an empty list report nothing valid.
    send_request(read_req(SLOT_W'(0)), 1'b1);
    send_request(read_req(SLOT_W'(31)), 1'b1);
    // Wildcard name: bytes past length 0 are noise, so the repeat is a hit.
    send_request(ingest_req('0, '0, '1, 8'h80, 4'd0), 1'b1);
    send_request(ingest_req('0, '0, random_name(), 8'h7f, 4'd14), 1'b1);
    // Full-length name, then an over-long length that clamps to the same record.
    send_request(ingest_req('1, LEN_W'(32), '1, 8'hff, 4'd9), 1'b1);
    send_request(ingest_req('1, LEN_W'(63), '1, 8'h01, 4'd14), 1'b1);
    // One byte shorter, and a differing last byte: both are new records.
    send_request(ingest_req('1, LEN_W'(31), '1, 8'h00, 4'd1), 1'b1);
    send_request(ingest_req('1, LEN_W'(32), {64'h00ff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff}, 8'h40, 4'd7), 1'b1);
    // Short name: only the first five bytes count.
    send_request(ingest_req(48'h0000_0000_0001, LEN_W'(5), {64'h0, 64'h0, 64'h0,
                 64'hdead_beef_c3b2_a190}, 8'hc0, 4'd6), 1'b1);
    send_request(ingest_req(48'h0000_0000_0001, LEN_W'(5), {64'h1111_2222_3333_4444,
                 64'h5555_6666_7777_8888, 64'h9999_aaaa_bbbb_cccc, 64'h1234_56ef_c3b2_a190},
                 8'h3f, 4'd11), 1'b1);
    // Wildcard record sits deep in the list now: hit away from the front.
    send_request(ingest_req('0, '0, '0, 8'h7f, 4'd3), 1'b1);
    // Same address, clamped length 32 against the wildcard: a miss.
    send_request(ingest_req('0, LEN_W'(33), random_name(), 8'h05, 4'd2), 1'b1);
    // Walk the list, then read just past its end.
    for (int s = 0; s <= 6; s++) send_request(read_req(SLOT_W'(s)), 1'b1);
    wait_for_drain();

    // Random traffic in segments; some segments run with no idling at all.
    sent       = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      seg_items   = $urandom_range(16, 96);
      for (int s = 0; s < seg_items && sent < RANDOM_ITEMS; s++) begin
        if (sent == HOLD_AT) begin
          // Receiver holds off while the sender keeps offering back to back.
          hold_request = 1'b1;
          burst_left   = HOLD_BURST;
        end
        if (sent == PAUSE_AT) wait_for_drain();
        req = ($urandom_range(0, 99) < 35) ? read_req(SLOT_W'($urandom)) : make_ingest();
        send_request(req, !steady_flow && burst_left == 0);
        if (burst_left != 0) burst_left--;
        sent++;
      end
    end

    wait_for_drain();
    // Let any stray response show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mtfd_pkg.sv
hdl/mtfd_if.sv
hdl/mtfd_cell.sv
hdl/move_to_front_dedup_list_unit.sv
hdl/mtfd_checker.sv
tb/mtfd_list_checker.sv
tb/tb_move_to_front_dedup_list_unit.sv
